@@ rtl/core/dwbg_pkg.sv @@
// Shared types and constants for the daily write budget gate.
package dwbg_pkg;

	localparam int TIME_W  = 56;
	localparam int BYTES_W = 48;
	localparam int BUCK_W  = 56;
	localparam int SUM_W   = 61;
	localparam int AGE_W   = TIME_W + 1;

	localparam logic signed [AGE_W-1:0] DAY_US   = 57'sd86400000000;
	localparam logic signed [AGE_W-1:0] WEEK_US  = 57'sd604800000000;
	localparam logic signed [AGE_W-1:0] MONTH_US = 57'sd2419200000000;

	typedef struct packed {
		logic               mode;
		logic [TIME_W-1:0]  event_time;
		logic [BYTES_W-1:0] bytes;
	} in_t;

	typedef struct packed {
		logic             swap_allowed;
		logic [SUM_W-1:0] sum_month;
		logic [SUM_W-1:0] sum_week;
		logic [SUM_W-1:0] sum_day;
	} out_t;

	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] start;
		logic [BUCK_W-1:0] bytes;
	} cell_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_TAKE,
		OP_ADD
	} cell_op_t;

	typedef struct packed {
		logic clear;
		logic sample;
	} win_ctrl_t;

endpackage

@@ rtl/core/daily_write_budget_gate.sv @@
// Daily write budget gate: bucket chain, window accumulator and control.
// Record: accepted in idle, then passes the compare and apply states; done strobes from the apply state.
// Query: the chain rotates once through the tail in the run state, then the drain and
// finish states let the window sums settle and compare them with the limits.
// Reset: one zero bucket at time 0 in the head cell, all limits zero.
// done is a single-cycle strobe; results cannot be stalled.
module daily_write_budget_gate #(
	parameter int HISTORY_DEPTH = 28
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  dwbg_pkg::in_t               cmd,
	output logic                        done,
	output dwbg_pkg::out_t              result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [dwbg_pkg::TIME_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(HISTORY_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REC_CMP,
		ST_REC_APPLY,
		ST_Q_RUN,
		ST_Q_DRAIN,
		ST_Q_FIN
	} state_t;

	state_t                            state_q;
	dwbg_pkg::in_t                     cmd_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic                              new_q;
	logic                              done_q;
	dwbg_pkg::out_t                    result_q;
	logic [dwbg_pkg::SUM_W-1:0]        lim_m_q, lim_w_q, lim_d_q;

	dwbg_pkg::cell_t                   cells [HISTORY_DEPTH];
	dwbg_pkg::cell_t                   head_in;
	dwbg_pkg::cell_op_t                body_op, head_op;
	dwbg_pkg::win_ctrl_t               win_ctrl;
	logic signed [dwbg_pkg::AGE_W-1:0] rec_age;
	logic [dwbg_pkg::SUM_W-1:0]        sum_m, sum_w, sum_d;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	assign rec_age = signed'({1'b0, cmd_q.event_time}) - signed'({1'b0, cells[0].start});

	always_comb begin
		if (state_q == ST_Q_RUN) begin
			head_in = cells[HISTORY_DEPTH-1];
		end else begin
			head_in.valid = 1'b1;
			head_in.start = cmd_q.event_time;
			head_in.bytes = dwbg_pkg::BUCK_W'(cmd_q.bytes);
		end
		body_op = ((state_q == ST_Q_RUN) || (state_q == ST_REC_APPLY && new_q)) ?
			dwbg_pkg::OP_TAKE : dwbg_pkg::OP_HOLD;
		head_op = (state_q == ST_REC_APPLY && !new_q) ? dwbg_pkg::OP_ADD : body_op;
	end

	for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
		if (k == 0) begin : g_head
			dwbg_cell #(.HEAD(1'b1)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.op        (head_op),
				.prev      (head_in),
				.add_bytes (cmd_q.bytes),
				.state     (cells[k])
			);
		end else begin : g_body
			dwbg_cell #(.HEAD(1'b0)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.op        (body_op),
				.prev      (cells[k-1]),
				.add_bytes (cmd_q.bytes),
				.state     (cells[k])
			);
		end
	end

	assign win_ctrl.clear  = start && !busy && cmd.mode;
	assign win_ctrl.sample = (state_q == ST_Q_RUN);

	dwbg_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (win_ctrl),
		.tail      (cells[HISTORY_DEPTH-1]),
		.now       (cmd_q.event_time),
		.sum_month (sum_m),
		.sum_week  (sum_w),
		.sum_day   (sum_d)
	);

	// limits: target * 28, * 14, * 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_m_q <= '0;
			lim_w_q <= '0;
			lim_d_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			lim_m_q <= {cfg_data, 5'b0} - {3'b0, cfg_data, 2'b0};
			lim_w_q <= {1'b0, cfg_data, 4'b0} - {4'b0, cfg_data, 1'b0};
			lim_d_q <= {3'b0, cfg_data, 2'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			new_q    <= 1'b0;
			done_q   <= 1'b0;
			cmd_q    <= '0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						cnt_q   <= '0;
						state_q <= cmd.mode ? ST_Q_RUN : ST_REC_CMP;
					end
				end
				ST_REC_CMP: begin
					new_q   <= (rec_age > dwbg_pkg::DAY_US);
					state_q <= ST_REC_APPLY;
				end
				ST_REC_APPLY: begin
					result_q <= '0;
					done_q   <= 1'b1;
					state_q  <= ST_IDLE;
				end
				ST_Q_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(HISTORY_DEPTH - 1)) state_q <= ST_Q_DRAIN;
				end
				ST_Q_DRAIN: state_q <= ST_Q_FIN;
				ST_Q_FIN: begin
					result_q.swap_allowed <= (sum_m < lim_m_q) && (sum_w < lim_w_q) &&
						(sum_d < lim_d_q);
					result_q.sum_month    <= sum_m;
					result_q.sum_week     <= sum_w;
					result_q.sum_day      <= sum_d;
					done_q                <= 1'b1;
					state_q               <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_Q_RUN) |-> cells[0].valid) else $error("head bucket lost");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held over two cycles");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transfer did not start work");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without work");

	a_record_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !cmd_q.mode) |-> (result == '0)) else $error("record result not zero");

endmodule

@@ rtl/core/dwbg_cell.sv @@
// One bucket cell of the history chain: holds, takes its neighbor, or adds bytes.
module dwbg_cell #(
	parameter bit HEAD = 1'b0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dwbg_pkg::cell_op_t           op,
	input  dwbg_pkg::cell_t              prev,
	input  logic [dwbg_pkg::BYTES_W-1:0] add_bytes,
	output dwbg_pkg::cell_t              state
);

	dwbg_pkg::cell_t         cell_q;
	logic [dwbg_pkg::BUCK_W:0] sum;

	assign sum   = {1'b0, cell_q.bytes} + (dwbg_pkg::BUCK_W+1)'(add_bytes);
	assign state = cell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q.valid <= HEAD;
			cell_q.start <= '0;
			cell_q.bytes <= '0;
		end else begin
			case (op)
				dwbg_pkg::OP_TAKE: cell_q <= prev;
				dwbg_pkg::OP_ADD: begin
					// saturate at all ones
					cell_q.bytes <= sum[dwbg_pkg::BUCK_W] ? '1 : sum[dwbg_pkg::BUCK_W-1:0];
				end
				default: cell_q <= cell_q;
			endcase
		end
	end

endmodule

@@ rtl/core/dwbg_window.sv @@
// Window accumulator at the chain tail: age check stage, then saturating sums.
module dwbg_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dwbg_pkg::win_ctrl_t         ctrl,
	input  dwbg_pkg::cell_t             tail,
	input  logic [dwbg_pkg::TIME_W-1:0] now,
	output logic [dwbg_pkg::SUM_W-1:0]  sum_month,
	output logic [dwbg_pkg::SUM_W-1:0]  sum_week,
	output logic [dwbg_pkg::SUM_W-1:0]  sum_day
);

	logic signed [dwbg_pkg::AGE_W-1:0] age;
	logic                              smp_s1;
	logic                              in_m_s1, in_w_s1, in_d_s1;
	logic [dwbg_pkg::BUCK_W-1:0]       bytes_s1;
	logic [dwbg_pkg::SUM_W-1:0]        acc_m_q, acc_w_q, acc_d_q;

	function automatic logic [dwbg_pkg::SUM_W-1:0] sat_add(
		input logic [dwbg_pkg::SUM_W-1:0]  a,
		input logic [dwbg_pkg::BUCK_W-1:0] b
	);
		logic [dwbg_pkg::SUM_W:0] s;
		s = {1'b0, a} + (dwbg_pkg::SUM_W+1)'(b);
		return s[dwbg_pkg::SUM_W] ? '1 : s[dwbg_pkg::SUM_W-1:0];
	endfunction

	assign age = signed'({1'b0, now}) - signed'({1'b0, tail.start});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s1   <= 1'b0;
			in_m_s1  <= 1'b0;
			in_w_s1  <= 1'b0;
			in_d_s1  <= 1'b0;
			bytes_s1 <= '0;
		end else begin
			smp_s1   <= ctrl.sample;
			in_m_s1  <= tail.valid && (age < dwbg_pkg::MONTH_US);
			in_w_s1  <= tail.valid && (age < dwbg_pkg::WEEK_US);
			in_d_s1  <= tail.valid && (age < dwbg_pkg::DAY_US);
			bytes_s1 <= tail.bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_m_q <= '0;
			acc_w_q <= '0;
			acc_d_q <= '0;
		end else if (ctrl.clear) begin
			acc_m_q <= '0;
			acc_w_q <= '0;
			acc_d_q <= '0;
		end else if (smp_s1) begin
			if (in_m_s1) acc_m_q <= sat_add(acc_m_q, bytes_s1);
			if (in_w_s1) acc_w_q <= sat_add(acc_w_q, bytes_s1);
			if (in_d_s1) acc_d_q <= sat_add(acc_d_q, bytes_s1);
		end
	end

	assign sum_month = acc_m_q;
	assign sum_week  = acc_w_q;
	assign sum_day   = acc_d_q;

endmodule

@@ test/dwbg_ledger_check.sv @@
// Bucket ledger predictor and result comparator for the daily write budget gate.
`timescale 1ns / 1ps

package dwbg_tb_pkg;

	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	localparam int RING_DEPTH = 28;

	localparam longint US_DAY   = 64'sd86400000000;
	localparam longint US_WEEK  = US_DAY * 7;
	localparam longint US_MONTH = US_DAY * 28;

endpackage

module dwbg_ledger_check #(
	parameter int DEPTH = 28
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  dwbg_pkg::in_t               cmd,
	input  logic                        done,
	input  dwbg_pkg::out_t              result,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [dwbg_pkg::TIME_W-1:0] cfg_data,
	output int                          outstanding,
	output int                          failures
);

	import dwbg_pkg::*;
	import dwbg_tb_pkg::*;

	localparam logic [63:0] BUCKET_CAP = (64'd1 << BUCK_W) - 64'd1;
	localparam logic [63:0] WINDOW_CAP = (64'd1 << SUM_W) - 64'd1;

	logic [TIME_W-1:0] opened_at [DEPTH];
	logic [BUCK_W-1:0] written   [DEPTH];
	int                filled;
	int                newest;
	logic [TIME_W-1:0] daily_target;

	out_t verdicts [$];
	out_t want;
	int   fail_tally;

	function automatic longint age_us(logic [TIME_W-1:0] now, logic [TIME_W-1:0] from);
		return $signed({8'd0, now}) - $signed({8'd0, from});
	endfunction

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
		logic [63:0] s;
		s = a + b;
		return (s > cap) ? cap : s;
	endfunction

	// applies one command to the ledger (records update it, queries read it) and returns its result
	function automatic out_t ledger_step(in_t c);
		out_t        r;
		logic [63:0] month_sum, week_sum, day_sum, v;
		logic [63:0] base;
		longint      age;
		int          slot;
		r = '0;
		if (c.mode == MODE_RECORD) begin
			if (age_us(c.event_time, opened_at[newest]) > US_DAY) begin
				newest = (newest + 1) % DEPTH;
				opened_at[newest] = c.event_time;
				written[newest] = BUCK_W'(c.bytes);
				if (filled < DEPTH)
					filled++;
			end else begin
				written[newest] = BUCK_W'(sat_add(64'(written[newest]), 64'(c.bytes),
					BUCKET_CAP));
			end
			return r;
		end
		month_sum = '0;
		week_sum = '0;
		day_sum = '0;
		for (int k = 0; k < filled; k++) begin
			slot = (newest + DEPTH - k) % DEPTH;
			age = age_us(c.event_time, opened_at[slot]);
			v = 64'(written[slot]);
			if (age < US_MONTH)
				month_sum = sat_add(month_sum, v, WINDOW_CAP);
			if (age < US_WEEK)
				week_sum = sat_add(week_sum, v, WINDOW_CAP);
			if (age < US_DAY)
				day_sum = sat_add(day_sum, v, WINDOW_CAP);
		end
		base = 64'(daily_target);
		r.swap_allowed = (month_sum < base * 28) && (week_sum < base * 14) &&
			(day_sum < base * 4);
		r.sum_month = month_sum[SUM_W-1:0];
		r.sum_week = week_sum[SUM_W-1:0];
		r.sum_day = day_sum[SUM_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				opened_at[k] = '0;
				written[k] = '0;
			end
			filled = 1;
			newest = 0;
			daily_target = '0;
			verdicts.delete();
			fail_tally = 0;
			outstanding <= 0;
			failures <= 0;
		end else begin
			if (done) begin
				if (verdicts.size() == 0) begin
					$error("result transfer with no command pending");
					fail_tally++;
				end else begin
					want = verdicts.pop_front();
					if (result.swap_allowed !== want.swap_allowed) begin
						$error("swap_allowed: expected %0d, got %0d",
							want.swap_allowed, result.swap_allowed);
						fail_tally++;
					end
					if (result.sum_month !== want.sum_month) begin
						$error("sum_month: expected %0d, got %0d",
							want.sum_month, result.sum_month);
						fail_tally++;
					end
					if (result.sum_week !== want.sum_week) begin
						$error("sum_week: expected %0d, got %0d",
							want.sum_week, result.sum_week);
						fail_tally++;
					end
					if (result.sum_day !== want.sum_day) begin
						$error("sum_day: expected %0d, got %0d",
							want.sum_day, result.sum_day);
						fail_tally++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				daily_target = cfg_data;
			if (start && !busy)
				verdicts.push_back(ledger_step(cmd));
			outstanding <= verdicts.size();
			failures <= fail_tally;
		end
	end

endmodule

@@ test/tb_daily_write_budget_gate.sv @@
// Stimulus, clock, reset and verdict for the daily write budget gate regression.
`timescale 1ns / 1ps

module tb_daily_write_budget_gate;

	import dwbg_pkg::*;
	import dwbg_tb_pkg::*;

	localparam int STALL_LIMIT   = 1000;
	localparam int ITEMS_PER_SET = 75;
	localparam int FILL_RECORDS  = 260;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	in_t               cmd       = '0;
	logic              cfg_valid = 1'b0;
	logic [TIME_W-1:0] cfg_data  = '0;
	logic              busy;
	logic              done;
	out_t              result;
	logic              cfg_ready;

	int                outstanding;
	int                fail_total;
	int                quiet_cycles = 0;
	int                burst_left = 0;
	logic [TIME_W-1:0] clock_us = '0;
	logic [TIME_W-1:0] anchor_us = '0;
	in_t               item;
	logic [63:0]       wide;

	daily_write_budget_gate #(
		.HISTORY_DEPTH(RING_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	dwbg_ledger_check #(
		.DEPTH(RING_DEPTH)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.outstanding(outstanding),
		.failures(fail_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("daily_write_budget_gate regression: fail");
		$finish;
	end

	function automatic in_t make_cmd(logic m, logic [TIME_W-1:0] t, logic [BYTES_W-1:0] b);
		in_t c;
		c.mode = m;
		c.event_time = t;
		c.bytes = b;
		return c;
	endfunction

	// sender issues bursts of random length, with a random idle gap (possibly none) before each
	task automatic issue(input in_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(1, 40);
				default: gap = $urandom_range(1, 4);
			endcase
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_target(input logic [TIME_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// record times move forward mostly; full-range times only on queries
	task automatic roll_event(output in_t c);
		int          pick;
		logic [63:0] step;
		longint      span;
		c.mode = ($urandom_range(0, 99) < 35) ? MODE_QUERY : MODE_RECORD;
		step = {$urandom(), $urandom()};
		c.bytes = step[BYTES_W-1:0] >> $urandom_range(0, BYTES_W - 1);
		pick = $urandom_range(0, 19);
		if (pick == 0)
			c.bytes = '1;
		else if (pick == 1)
			c.bytes = '0;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			step = 64'($urandom_range(0, 21600)) * 64'd1000000 + 64'($urandom_range(0, 999999));
			clock_us = clock_us + step[TIME_W-1:0];
		end else if (pick < 66) begin
			step = 64'($urandom_range(0, 172800)) * 64'd1000000 + 64'(US_DAY) + 64'd1;
			clock_us = clock_us + step[TIME_W-1:0];
			anchor_us = clock_us;
		end else if (pick < 74) begin
			step = 64'($urandom_range(0, 172800)) * 64'd1000000;
			clock_us = clock_us - step[TIME_W-1:0];
		end else if (pick < 80) begin
			step = 64'($urandom_range(7, 30)) * 64'(US_DAY);
			clock_us = clock_us + step[TIME_W-1:0];
			anchor_us = clock_us;
		end else if (pick < 83) begin
			step = {16'd0, 16'($urandom_range(0, 65535)), $urandom()};
			clock_us = clock_us + step[TIME_W-1:0];
			anchor_us = clock_us;
		end
		c.event_time = clock_us;
		if (pick >= 83 && pick < 95) begin
			case ($urandom_range(0, 2))
				0: span = US_DAY;
				1: span = US_WEEK;
				default: span = US_MONTH;
			endcase
			c.event_time = anchor_us + TIME_W'(span) + TIME_W'($urandom_range(0, 2)) -
				TIME_W'(1);
		end else if (pick >= 95 && c.mode == MODE_QUERY) begin
			step = {$urandom(), $urandom()};
			c.event_time = step[TIME_W-1:0];
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_target('1);
		issue(make_cmd(MODE_QUERY, '0, '0));
		issue(make_cmd(MODE_RECORD, '0, '1));
		issue(make_cmd(MODE_RECORD, TIME_W'(US_DAY), BYTES_W'(1)));
		issue(make_cmd(MODE_RECORD, TIME_W'(US_DAY + 1), '0));
		issue(make_cmd(MODE_QUERY, TIME_W'(US_DAY), '1));
		issue(make_cmd(MODE_QUERY, TIME_W'(2 * US_DAY + 1), '0));
		issue(make_cmd(MODE_QUERY, TIME_W'(US_WEEK), '0));
		issue(make_cmd(MODE_QUERY, TIME_W'(US_MONTH), '0));
		issue(make_cmd(MODE_RECORD, TIME_W'(5), '1));
		issue(make_cmd(MODE_QUERY, '1, '0));
		issue(make_cmd(MODE_QUERY, '0, '0));
		write_target('0);
		issue(make_cmd(MODE_QUERY, TIME_W'(US_DAY + 1), '0));

		// one bucket pushed into saturation
		clock_us = TIME_W'(3 * US_DAY + 7);
		anchor_us = clock_us;
		for (int n = 0; n < FILL_RECORDS; n++)
			issue(make_cmd(MODE_RECORD, clock_us, '1));
		issue(make_cmd(MODE_QUERY, clock_us, '0));
		write_target(TIME_W'(1));
		issue(make_cmd(MODE_QUERY, clock_us + TIME_W'(US_DAY), '0));

		for (int p = 0; p < 5; p++) begin
			wide = {$urandom(), $urandom()};
			case (p)
				0: write_target('0);
				1: write_target('1);
				default: write_target(wide[TIME_W-1:0] >> $urandom_range(8, 24));
			endcase
			for (int n = 0; n < ITEMS_PER_SET; n++) begin
				if ($urandom_range(0, 39) == 0)
					drain();
				roll_event(item);
				issue(item);
			end
		end

		drain();
		repeat (RING_DEPTH + 3) @(posedge clk);
		if (fail_total == 0)
			$display("daily_write_budget_gate regression: pass");
		else
			$display("daily_write_budget_gate regression: fail");
		$finish;
	end

endmodule
